FILE: hdl/e2r_pkg.sv
// Package for the Euler angle to rotation matrix block.
// Holds CORDIC constants and the arctangent table; no dependencies.
`default_nettype none
package e2r_pkg;
    localparam int STEPS = 30;
    localparam int ZW = 34;
    localparam int XW = 32;
    localparam logic signed [ZW-1:0] FIX_PI = 34'sd3373259426;
    localparam logic signed [ZW-1:0] FIX_HALF_PI = 34'sd1686629713;
    localparam logic signed [XW-1:0] FIX_GAIN = 32'sd652032874;

    function automatic logic signed [ZW-1:0] arc_tab(input int i);
        case (i)
            0: arc_tab = 34'sd843314857;
            1: arc_tab = 34'sd497837829;
            2: arc_tab = 34'sd263043837;
            3: arc_tab = 34'sd133525159;
            4: arc_tab = 34'sd67021687;
            5: arc_tab = 34'sd33543516;
            6: arc_tab = 34'sd16775851;
            7: arc_tab = 34'sd8388437;
            8: arc_tab = 34'sd4194283;
            9: arc_tab = 34'sd2097149;
            default: arc_tab = ZW'(64'sd1 <<< (30 - i));
        endcase
    endfunction
endpackage
`default_nettype wire

FILE: hdl/e2r_cordic.sv
// Pipelined circular CORDIC lane: one stage per iteration, sine and cosine in Q30.
// Depends on e2r_pkg.
`default_nettype none
module e2r_cordic
    import e2r_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic signed [ANGLE_WIDTH-1:0] angle,
    output logic signed [XW-1:0]               sin_q30,
    output logic signed [XW-1:0]               cos_q30
);
    logic signed [XW-1:0] x_reg [STEPS+1];
    logic signed [XW-1:0] y_reg [STEPS+1];
    logic signed [ZW-1:0] z_reg [STEPS+1];
    logic                 f_reg [STEPS+1];
    logic signed [ZW-1:0] z_in;

    assign z_in = ZW'(angle) <<< (33 - ANGLE_WIDTH);

    always_ff @(posedge clk)
    begin
        x_reg[0] <= FIX_GAIN;
        y_reg[0] <= '0;
        if (z_in > FIX_HALF_PI)
        begin
            z_reg[0] <= z_in - FIX_PI;
            f_reg[0] <= 1'b1;
        end
        else if (z_in < -FIX_HALF_PI)
        begin
            z_reg[0] <= z_in + FIX_PI;
            f_reg[0] <= 1'b1;
        end
        else
        begin
            z_reg[0] <= z_in;
            f_reg[0] <= 1'b0;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            f_reg[i+1] <= f_reg[i];
            if (!z_reg[i][ZW-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - arc_tab(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + arc_tab(i);
            end
        end
    end

    assign cos_q30 = f_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
    assign sin_q30 = f_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
endmodule
`default_nettype wire

FILE: hdl/e2r_merge.sv
// Merge stage: combines the three lanes' sines and cosines into nine matrix entries.
// Three register stages; depends on e2r_pkg.
`default_nettype none
module e2r_merge
    import e2r_pkg::*;
#(
    parameter int ENTRY_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic signed [XW-1:0] sb,
    input  wire logic signed [XW-1:0] cb,
    input  wire logic signed [XW-1:0] sa,
    input  wire logic signed [XW-1:0] ca,
    input  wire logic signed [XW-1:0] sh,
    input  wire logic signed [XW-1:0] ch,
    output logic signed [ENTRY_WIDTH-1:0] entry [9]
);
    localparam int SH = 62 - ENTRY_WIDTH;
    localparam logic signed [65:0] LIM = 66'sd1 <<< (ENTRY_WIDTH - 2);
    localparam logic signed [65:0] HALF = 66'sd1 <<< (SH - 1);

    logic signed [63:0] sasb_p_reg, sacb_p_reg;
    logic signed [XW-1:0] sb1_reg, cb1_reg, sa1_reg, ca1_reg, sh1_reg, ch1_reg;
    logic signed [XW:0] sasb, sacb;
    logic signed [65:0] v_reg [9];

    function automatic logic signed [ENTRY_WIDTH-1:0] finish(input logic signed [65:0] v);
        logic signed [65:0] r;
        r = (v + HALF) >>> SH;
        if (r > LIM) r = LIM;
        if (r < -LIM) r = -LIM;
        finish = r[ENTRY_WIDTH-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        sasb_p_reg <= sa * sb;
        sacb_p_reg <= sa * cb;
        sb1_reg <= sb;
        cb1_reg <= cb;
        sa1_reg <= sa;
        ca1_reg <= ca;
        sh1_reg <= sh;
        ch1_reg <= ch;
    end

    assign sasb = (XW+1)'((sasb_p_reg + (64'sd1 <<< 29)) >>> 30);
    assign sacb = (XW+1)'((sacb_p_reg + (64'sd1 <<< 29)) >>> 30);

    always_ff @(posedge clk)
    begin
        v_reg[0] <= 66'(ch1_reg * ca1_reg);
        v_reg[1] <= 66'(sh1_reg * sb1_reg) - 66'(ch1_reg * sacb);
        v_reg[2] <= 66'(ch1_reg * sasb) + 66'(sh1_reg * cb1_reg);
        v_reg[3] <= 66'(sa1_reg) <<< 30;
        v_reg[4] <= 66'(ca1_reg * cb1_reg);
        v_reg[5] <= -66'(ca1_reg * sb1_reg);
        v_reg[6] <= -66'(sh1_reg * ca1_reg);
        v_reg[7] <= 66'(sh1_reg * sacb) + 66'(ch1_reg * sb1_reg);
        v_reg[8] <= 66'(ch1_reg * cb1_reg) - 66'(sh1_reg * sasb);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            entry[k] <= finish(v_reg[k]);
    end
endmodule
`default_nettype wire

FILE: hdl/euler_to_rotation_matrix.sv
// Euler angles to rotation matrix: three CORDIC lanes and a merge stage.
// done follows start through a valid pipeline; one transaction per cycle, busy stays low.
// Depth set by the 31 CORDIC stages plus three merge stages.
// Reset clears only the valid pipeline; payload registers are not reset.
// Depends on e2r_pkg, e2r_cordic, e2r_merge.
`default_nettype none
module euler_to_rotation_matrix
    import e2r_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16,
    parameter int ENTRY_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [ANGLE_WIDTH-1:0] bank_angle,
    input  wire logic signed [ANGLE_WIDTH-1:0] attitude_angle,
    input  wire logic signed [ANGLE_WIDTH-1:0] heading_angle,
    output logic                               done,
    output logic signed [ENTRY_WIDTH-1:0]      entry_r0c0,
    output logic signed [ENTRY_WIDTH-1:0]      entry_r0c1,
    output logic signed [ENTRY_WIDTH-1:0]      entry_r0c2,
    output logic signed [ENTRY_WIDTH-1:0]      entry_r1c0,
    output logic signed [ENTRY_WIDTH-1:0]      entry_r1c1,
    output logic signed [ENTRY_WIDTH-1:0]      entry_r1c2,
    output logic signed [ENTRY_WIDTH-1:0]      entry_r2c0,
    output logic signed [ENTRY_WIDTH-1:0]      entry_r2c1,
    output logic signed [ENTRY_WIDTH-1:0]      entry_r2c2
);
    localparam int LAT = STEPS + 4;

    logic [LAT-1:0] valid_reg, valid_next;
    logic signed [XW-1:0] sb, cb, sa, ca, sh, ch;
    logic signed [ENTRY_WIDTH-1:0] entry [9];

    assign busy = 1'b0;
    assign valid_next = {valid_reg[LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    e2r_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_bank
        (.clk(clk), .angle(bank_angle), .sin_q30(sb), .cos_q30(cb));
    e2r_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_att
        (.clk(clk), .angle(attitude_angle), .sin_q30(sa), .cos_q30(ca));
    e2r_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_head
        (.clk(clk), .angle(heading_angle), .sin_q30(sh), .cos_q30(ch));

    e2r_merge #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_merge
        (.clk(clk), .sb(sb), .cb(cb), .sa(sa), .ca(ca), .sh(sh), .ch(ch), .entry(entry));

    assign done = valid_reg[LAT-1];
    assign entry_r0c0 = entry[0];
    assign entry_r0c1 = entry[1];
    assign entry_r0c2 = entry[2];
    assign entry_r1c0 = entry[3];
    assign entry_r1c1 = entry[4];
    assign entry_r1c2 = entry[5];
    assign entry_r2c0 = entry[6];
    assign entry_r2c1 = entry[7];
    assign entry_r2c2 = entry[8];
endmodule
`default_nettype wire

FILE: test/testbench.sv
// Testbench for euler_to_rotation_matrix: drives angle triples, predicts the nine
// matrix entries with a bit-exact CORDIC model and checks each done transaction.
// Depends on e2r_pkg and the euler_to_rotation_matrix RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import e2r_pkg::*;

    localparam int AW = 16;
    localparam int EW = 16;
    localparam int LATENCY = 34;
    localparam int LIMIT = 200000;
    localparam int NUM_RANDOM = 630;

    typedef struct packed {
        logic signed [AW-1:0] bank;
        logic signed [AW-1:0] att;
        logic signed [AW-1:0] head;
    } angles_t;

    typedef logic signed [EW-1:0] entry_t;
    typedef struct packed {
        entry_t [8:0] e;
    } matrix_t;

    typedef struct {
        angles_t a;
        bit      has_val;
        matrix_t m;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    logic signed [AW-1:0] bank_angle = '0;
    logic signed [AW-1:0] attitude_angle = '0;
    logic signed [AW-1:0] heading_angle = '0;
    entry_t entry_r0c0, entry_r0c1, entry_r0c2, entry_r1c0, entry_r1c1;
    entry_t entry_r1c2, entry_r2c0, entry_r2c1, entry_r2c2;

    matrix_t expected_matrices[$];
    int errors = 0;
    longint cycles = 0;

    euler_to_rotation_matrix #(.ANGLE_WIDTH(AW), .ENTRY_WIDTH(EW)) dut (
        .clk, .rst_n, .start, .busy, .bank_angle, .attitude_angle, .heading_angle,
        .done, .entry_r0c0, .entry_r0c1, .entry_r0c2, .entry_r1c0, .entry_r1c1,
        .entry_r1c2, .entry_r2c0, .entry_r2c1, .entry_r2c2
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void sine_cosine(logic signed [AW-1:0] ang,
                                        output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ang) * (64'sd1 <<< (33 - AW));
        x = longint'(FIX_GAIN);
        y = 0;
        flip = 0;
        if (z > longint'(FIX_HALF_PI))
        begin
            z -= longint'(FIX_PI);
            flip = 1;
        end
        else if (z < -longint'(FIX_HALF_PI))
        begin
            z += longint'(FIX_PI);
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= (i < 10) ? longint'(arc_tab(i)) : (64'sd1 <<< (30 - i));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += (i < 10) ? longint'(arc_tab(i)) : (64'sd1 <<< (30 - i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic entry_t round_entry(longint v);
        longint r, lim;
        lim = 64'sd1 <<< (EW - 2);
        r = fshr(v + (64'sd1 <<< (61 - EW)), 62 - EW);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return entry_t'(r);
    endfunction

    function automatic matrix_t rotation_of(angles_t a);
        longint sb, cb, sa, ca, sh, ch, sasb, sacb;
        matrix_t m;
        sine_cosine(a.bank, sb, cb);
        sine_cosine(a.att, sa, ca);
        sine_cosine(a.head, sh, ch);
        sasb = fshr(sa * sb + (64'sd1 <<< 29), 30);
        sacb = fshr(sa * cb + (64'sd1 <<< 29), 30);
        m.e[0] = round_entry(ch * ca);
        m.e[1] = round_entry(sh * sb - ch * sacb);
        m.e[2] = round_entry(ch * sasb + sh * cb);
        m.e[3] = round_entry(sa * (64'sd1 <<< 30));
        m.e[4] = round_entry(ca * cb);
        m.e[5] = round_entry(-(ca * sb));
        m.e[6] = round_entry(-(sh * ca));
        m.e[7] = round_entry(sh * sacb + ch * sb);
        m.e[8] = round_entry(ch * cb - sh * sasb);
        return m;
    endfunction

    task automatic report(string what, int idx, entry_t got, entry_t want);
        $display("mismatch %s entry %0d: got %0d expected %0d", what, idx, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        matrix_t got, want;
        if (rst_n && done)
        begin
            got.e = {entry_r2c2, entry_r2c1, entry_r2c0, entry_r1c2, entry_r1c1,
                     entry_r1c0, entry_r0c2, entry_r0c1, entry_r0c0};
            if (expected_matrices.size() == 0)
                report("unexpected transaction", 0, got.e[0], '0);
            else
            begin
                want = expected_matrices.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got.e[i] !== want.e[i])
                        report("field", i, got.e[i], want.e[i]);
            end
        end
    end

    localparam entry_t ONE = entry_t'(1 <<< (EW - 2));

    task automatic send(angles_t a, bit quiet);
        if (!quiet && $urandom_range(99) < 20)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        bank_angle <= a.bank;
        attitude_angle <= a.att;
        heading_angle <= a.head;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_matrices.push_back(rotation_of(a));
    endtask

    initial
    begin
        vec_t directed[$];
        vec_t v;
        angles_t a;
        matrix_t ident;
        int wait_cycles;
        logic signed [AW-1:0] vals[];
        ident.e = {ONE, entry_t'(0), entry_t'(0), entry_t'(0), ONE, entry_t'(0),
                   entry_t'(0), entry_t'(0), ONE};
        directed.push_back('{'{16'sd0, 16'sd0, 16'sd0}, 1, ident});
        vals = '{16'sh7FFF, 16'sh8000, 16'sd12868, -16'sd12868,
                 16'sd25736, -16'sd25736, 16'sd1, -16'sd1,
                 16'sd6434, -16'sd6434, 16'sd13820, 16'sh5555};
        foreach (vals[i])
        begin
            directed.push_back('{'{vals[i], vals[(i + 3) % 12], vals[(i + 7) % 12]},
                                 0, ident});
            if (i < 6)
                directed.push_back('{'{vals[i], vals[i], vals[i]}, 0, ident});
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
        begin
            v = directed[i];
            if (v.has_val && rotation_of(v.a) !== v.m)
                report("model table", i, rotation_of(v.a).e[0], v.m.e[0]);
            send(v.a, 1'b0);
        end
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            a.bank = AW'($urandom);
            a.att = AW'($urandom);
            a.head = AW'($urandom);
            send(a, n >= 200 && n < 350);
        end
        start <= 1'b0;
        wait_cycles = 0;
        while (expected_matrices.size() != 0 && wait_cycles < 10 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 5) @(posedge clk);
        if (errors == 0 && expected_matrices.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

FILE: files.f
hdl/e2r_pkg.sv
hdl/e2r_cordic.sv
hdl/e2r_merge.sv
hdl/euler_to_rotation_matrix.sv
test/testbench.sv
